/* hdl/sne_pkg.sv */
// ----------------------------------------------------------------------------
// sne_pkg
// Shared constants, codes and types of the SIS network event step core.
// ----------------------------------------------------------------------------
`default_nettype none

package sne_pkg;

  // graph storage
  localparam int MAX_NODES          = 1024;
  localparam int MAX_DIRECTED_EDGES = 8192;
  localparam int RATE_FRACTION_BITS = 14;

  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int EDGE_W   = $clog2(MAX_DIRECTED_EDGES);
  localparam int COUNT_W  = NODE_W + 1;
  localparam int PREFIX_W = 14;
  localparam int LAMBDA_W = 16;
  localparam int RATE_W   = 31;
  localparam int OUTRATE_W = 30;
  localparam int WORD_W   = 32;

  // input operations
  typedef enum logic [1:0] {
    OP_LOAD_DEGREE   = 2'd0,
    OP_LOAD_NEIGHBOR = 2'd1,
    OP_START         = 2'd2,
    OP_STEP          = 2'd3
  } op_t;

  // reported events
  typedef enum logic [2:0] {
    EV_DONE      = 3'd0,
    EV_RECOVERY  = 3'd1,
    EV_INFECTION = 3'd2,
    EV_ALREADY   = 3'd3,
    EV_EXTINCT   = 3'd4,
    EV_INCONSIST = 3'd5
  } event_t;

  // configuration register indexes
  typedef enum logic {
    REG_INFECTION_RATE = 1'b0,
    REG_NODE_COUNT     = 1'b1
  } reg_index_t;

  localparam logic [LAMBDA_W-1:0] INFECTION_RATE_RESET = 16'd1638;
  localparam logic [COUNT_W-1:0]  NODE_COUNT_RESET     = 11'd1024;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_RATE_MUL,
    S_RATE_SUM,
    S_Q_MUL,
    S_Q_SUM,
    S_DECIDE,
    S_REC_FLAG,
    S_REC_CHK,
    S_REC_MOVE,
    S_BIS_RD,
    S_BIS_MUL,
    S_BIS_CMP,
    S_FIN_MUL,
    S_FIN_CHK,
    S_MOD,
    S_SLOT_RD,
    S_SLOT,
    S_NBR,
    S_NBR2,
    S_INF_WR,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* hdl/sis_network_event_step_core.sv */
// ----------------------------------------------------------------------------
// sis_network_event_step_core
// SIS epidemic on a graph: one event drawn per step transaction, graph loaded
// in compressed row form, all state held in on-chip memories.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is high only while idle.
// A start sweeps all 1024 node entries. A step first draws the event; a
// recovery then moves each list entry behind the removed node down, one
// entry per cycle, and an infection runs a bisection over the infected
// prefix degrees (10 steps at most), then takes the remainder of the
// neighbor word by the source degree, one bit a cycle.
// A single 32x32 multiplier is shared by the rate, the event point and the
// bisection thresholds; every memory has one read and one write port.
// No clearing pass follows reset: infection flags are only read after a start
// has rewritten all of them.
`default_nettype none

module sis_network_event_step_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [12:0] table_index,
  input  wire logic [13:0] table_value,
  input  wire logic [31:0] choice_random,
  input  wire logic [31:0] neighbor_random,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_kind,
  output logic [9:0]       affected_node,
  output logic [10:0]      infected_count,
  output logic [29:0]      total_rate,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NW = sne_pkg::NODE_W;
  localparam int CW = sne_pkg::COUNT_W;
  localparam int PW = sne_pkg::PREFIX_W;
  localparam int EW = sne_pkg::EDGE_W;
  localparam int RW = sne_pkg::RATE_W;
  localparam int WW = sne_pkg::WORD_W;
  localparam int FB = sne_pkg::RATE_FRACTION_BITS;
  localparam logic [CW-1:0] NMAX = CW'(sne_pkg::MAX_NODES);

  // memories
  logic [PW-1:0] ndp_mem  [sne_pkg::MAX_NODES];
  logic [NW-1:0] nbr_mem  [sne_pkg::MAX_DIRECTED_EDGES];
  logic          flag_mem [sne_pkg::MAX_NODES];
  logic [NW-1:0] lst_mem  [sne_pkg::MAX_NODES];
  logic [PW-1:0] idp_mem  [sne_pkg::MAX_NODES];

  logic          ndp_we, nbr_we, flag_we, lst_we, idp_we;
  logic [NW-1:0] ndp_wa, flag_wa, lst_wa, idp_wa;
  logic [EW-1:0] nbr_wa, nbr_ra;
  logic [PW-1:0] ndp_wd, idp_wd;
  logic [NW-1:0] nbr_wd, lst_wd;
  logic          flag_wd;
  logic [NW-1:0] ndp_ra, flag_ra, lst_ra, idp_ra;
  logic [PW-1:0] ndp_rd, idp_rd;
  logic [NW-1:0] nbr_rd, lst_rd;
  logic          flag_rd;

  always_ff @(posedge clk) begin
    if (ndp_we) ndp_mem[ndp_wa] <= ndp_wd;
    ndp_rd <= ndp_mem[ndp_ra];
  end

  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_rd <= nbr_mem[nbr_ra];
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_rd <= flag_mem[flag_ra];
  end

  always_ff @(posedge clk) begin
    if (lst_we) lst_mem[lst_wa] <= lst_wd;
    lst_rd <= lst_mem[lst_ra];
  end

  always_ff @(posedge clk) begin
    if (idp_we) idp_mem[idp_wa] <= idp_wd;
    idp_rd <= idp_mem[idp_ra];
  end

  // registers
  sne_pkg::state_t state, state_next;
  logic [15:0]   infection_rate;
  logic [CW-1:0] node_count;
  logic [CW-1:0] infected_total, infected_total_next;
  logic [2:0]    ev, ev_next;
  logic [NW-1:0] node, node_next;
  logic [29:0]   rate_out, rate_out_next;
  logic [63:0]   prod, prod_next;
  logic [RW-1:0] rate, rate_next;
  logic [RW-1:0] q, q_next;
  logic          frac, frac_next;
  logic [CW-1:0] n_inf, n_inf_next;
  logic [PW-1:0] ptot, ptot_next;
  logic [PW-1:0] a_reg, a_reg_next;
  logic [PW-1:0] k, k_next;
  logic [NW-1:0] lower, lower_next, upper, upper_next, mid, mid_next;
  logic [NW-1:0] j, j_next;
  logic [NW-1:0] src, src_next;
  logic [PW-1:0] rem, rem_next;
  logic [WW-1:0] nr_sh, nr_sh_next;
  logic [WW-1:0] r_in, r_in_next;
  logic [4:0]    bit_cnt, bit_cnt_next;
  logic [CW-1:0] sc, sc_next;
  logic [NW-1:0] sc_d;
  logic          sw_v;
  logic          out_load;

  // shared multiplier
  logic [WW-1:0] mul_a, mul_b;
  logic [63:0]   mul_res;
  assign mul_res = mul_a * mul_b;

  // helpers
  logic [CW-1:0] nclamp;
  logic [63:0]   qsum;
  logic [RW-1:0] rec, th;
  logic          gt;
  logic [CW-1:0] mid_sum;
  logic [PW:0]   rem_sh;
  logic [15:0]   slot;
  logic [PW-1:0] k_calc, deg_calc;

  assign nclamp  = (node_count > NMAX) ? NMAX : node_count;
  assign qsum    = {prod[62:0], 1'b0} + {{(64-RW){1'b0}}, rate};
  assign rec     = {{(RW-CW-FB){1'b0}}, n_inf, {FB{1'b0}}};
  assign th      = {1'b0, prod[29:0]};
  assign gt      = (q > th) || ((q == th) && frac);
  assign mid_sum = {1'b0, lower} + {1'b0, upper};
  assign rem_sh  = {rem, nr_sh[WW-1]};
  assign slot    = {2'b00, ndp_rd} - {2'b00, rem} - 16'd1;
  assign k_calc  = (j == '0) ? a_reg : (a_reg - idp_rd);
  assign deg_calc = (src == '0) ? a_reg : (a_reg - ndp_rd);

  assign in_ready  = (state == sne_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer: next state, datapath and memory control
  always_comb begin
    state_next = state;
    infected_total_next = infected_total;
    ev_next = ev;  node_next = node;  rate_out_next = rate_out;
    prod_next = prod;  rate_next = rate;  q_next = q;  frac_next = frac;
    n_inf_next = n_inf;  ptot_next = ptot;  a_reg_next = a_reg;  k_next = k;
    lower_next = lower;  upper_next = upper;  mid_next = mid;  j_next = j;
    src_next = src;  rem_next = rem;  nr_sh_next = nr_sh;  r_in_next = r_in;
    bit_cnt_next = bit_cnt;  sc_next = sc;
    out_load = 1'b0;
    mul_a = {{(WW-16){1'b0}}, infection_rate};
    mul_b = {{(WW-PW){1'b0}}, idp_rd};
    ndp_we = 1'b0;  ndp_wa = table_index[NW-1:0];  ndp_wd = table_value;
    nbr_we = 1'b0;  nbr_wa = table_index[EW-1:0];  nbr_wd = table_value[NW-1:0];
    flag_we = 1'b0; flag_wa = src;  flag_wd = 1'b0;
    lst_we = 1'b0;  lst_wa = j;  lst_wd = lst_rd;
    idp_we = 1'b0;  idp_wa = j;  idp_wd = idp_rd;
    ndp_ra = src;  nbr_ra = slot[EW-1:0];  flag_ra = src;  lst_ra = j;  idp_ra = j;

    unique case (state)
      sne_pkg::S_IDLE: begin
        idp_ra = NW'(infected_total - 1'b1);
        if (in_valid) begin
          ev_next = sne_pkg::EV_DONE;
          node_next = '0;
          rate_out_next = '0;
          r_in_next = choice_random;
          nr_sh_next = neighbor_random;
          n_inf_next = infected_total;
          state_next = sne_pkg::S_FINISH;
          unique case (sne_pkg::op_t'(operation))
            sne_pkg::OP_LOAD_DEGREE: ndp_we = (table_index[12:NW] == '0);
            sne_pkg::OP_LOAD_NEIGHBOR: nbr_we = 1'b1;
            sne_pkg::OP_START: begin
              sc_next = '0;
              state_next = sne_pkg::S_START;
            end
            sne_pkg::OP_STEP: begin
              if (infected_total == '0) ev_next = sne_pkg::EV_EXTINCT;
              else state_next = sne_pkg::S_RATE_MUL;
            end
            default: state_next = sne_pkg::S_FINISH;
          endcase
        end
      end

      // flags for every node, list and degree prefixes for active nodes, one per cycle
      sne_pkg::S_START: begin
        ndp_ra = sc[NW-1:0];
        flag_we = ~sc[NW];
        flag_wa = sc[NW-1:0];
        flag_wd = (sc < nclamp);
        lst_we = ~sc[NW] && (sc < nclamp);
        lst_wa = sc[NW-1:0];
        lst_wd = sc[NW-1:0];
        idp_we = sw_v && ({1'b0, sc_d} < nclamp);
        idp_wa = sc_d;
        idp_wd = ndp_rd;
        sc_next = sc + 1'b1;
        if (sc[NW]) begin
          infected_total_next = nclamp;
          state_next = sne_pkg::S_FINISH;
        end
      end

      // total rate and event point
      sne_pkg::S_RATE_MUL: begin
        prod_next = mul_res;
        ptot_next = idp_rd;
        state_next = sne_pkg::S_RATE_SUM;
      end
      sne_pkg::S_RATE_SUM: begin
        rate_next = RW'(prod[29:0]) + rec;
        state_next = sne_pkg::S_Q_MUL;
      end
      sne_pkg::S_Q_MUL: begin
        mul_a = r_in;
        mul_b = {{(WW-RW){1'b0}}, rate};
        prod_next = mul_res;
        rate_out_next = rate[RW-1] ? '1 : rate[29:0];
        state_next = sne_pkg::S_Q_SUM;
      end
      sne_pkg::S_Q_SUM: begin
        q_next = qsum[63:33];
        frac_next = |qsum[32:0];
        state_next = sne_pkg::S_DECIDE;
      end
      sne_pkg::S_DECIDE: begin
        if (q < rec) begin
          j_next = q[FB+NW-1:FB];
          lst_ra = q[FB+NW-1:FB];
          idp_ra = q[FB+NW-1:FB];
          state_next = sne_pkg::S_REC_FLAG;
        end else begin
          q_next = q - rec;
          lower_next = '0;
          upper_next = NW'(n_inf - 1'b1);
          state_next = sne_pkg::S_BIS_RD;
        end
      end

      // recovery
      sne_pkg::S_REC_FLAG: begin
        node_next = lst_rd;
        src_next = lst_rd;
        flag_ra = lst_rd;
        a_reg_next = idp_rd;
        idp_ra = j - 1'b1;
        state_next = sne_pkg::S_REC_CHK;
      end
      sne_pkg::S_REC_CHK: begin
        idp_ra = j + 1'b1;
        lst_ra = j + 1'b1;
        if (!flag_rd) begin
          ev_next = sne_pkg::EV_INCONSIST;
          state_next = sne_pkg::S_FINISH;
        end else begin
          k_next = k_calc;
          flag_we = 1'b1;
          flag_wa = src;
          flag_wd = 1'b0;
          if (({1'b0, j} + 1'b1) < n_inf) begin
            state_next = sne_pkg::S_REC_MOVE;
          end else begin
            infected_total_next = n_inf - 1'b1;
            ev_next = sne_pkg::EV_RECOVERY;
            state_next = sne_pkg::S_FINISH;
          end
        end
      end
      // shift the list down by one entry per cycle
      sne_pkg::S_REC_MOVE: begin
        idp_we = 1'b1;
        idp_wd = idp_rd - k;
        lst_we = 1'b1;
        lst_wd = lst_rd;
        idp_ra = j + 2'd2;
        lst_ra = j + 2'd2;
        if (({1'b0, j} + 2'd2) < n_inf) begin
          j_next = j + 1'b1;
        end else begin
          infected_total_next = n_inf - 1'b1;
          ev_next = sne_pkg::EV_RECOVERY;
          state_next = sne_pkg::S_FINISH;
        end
      end

      // bisection over infected prefix degrees
      sne_pkg::S_BIS_RD: begin
        if (lower < upper) begin
          mid_next = mid_sum[CW-1:1];
          idp_ra = mid_sum[CW-1:1];
          state_next = sne_pkg::S_BIS_MUL;
        end else begin
          idp_ra = lower;
          lst_ra = lower;
          j_next = lower;
          state_next = sne_pkg::S_FIN_MUL;
        end
      end
      sne_pkg::S_BIS_MUL: begin
        prod_next = mul_res;
        state_next = sne_pkg::S_BIS_CMP;
      end
      sne_pkg::S_BIS_CMP: begin
        if (gt) lower_next = mid + 1'b1;
        else upper_next = mid;
        state_next = sne_pkg::S_BIS_RD;
      end
      sne_pkg::S_FIN_MUL: begin
        prod_next = mul_res;
        a_reg_next = idp_rd;
        src_next = lst_rd;
        node_next = lst_rd;
        idp_ra = j - 1'b1;
        state_next = sne_pkg::S_FIN_CHK;
      end
      sne_pkg::S_FIN_CHK: begin
        k_next = k_calc;
        rem_next = '0;
        bit_cnt_next = '0;
        if (gt || (k_calc == '0)) begin
          ev_next = sne_pkg::EV_INCONSIST;
          state_next = sne_pkg::S_FINISH;
        end else begin
          state_next = sne_pkg::S_MOD;
        end
      end

      // neighbor word modulo source degree, one bit per cycle
      sne_pkg::S_MOD: begin
        rem_next = (rem_sh >= {1'b0, k}) ? PW'(rem_sh - {1'b0, k}) : rem_sh[PW-1:0];
        nr_sh_next = {nr_sh[WW-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == '1) state_next = sne_pkg::S_SLOT_RD;
      end
      sne_pkg::S_SLOT_RD: begin
        ndp_ra = src;
        state_next = sne_pkg::S_SLOT;
      end
      sne_pkg::S_SLOT: begin
        nbr_ra = slot[EW-1:0];
        if (slot[15] || (slot[14:EW] != '0)) begin
          ev_next = sne_pkg::EV_INCONSIST;
          state_next = sne_pkg::S_FINISH;
        end else begin
          state_next = sne_pkg::S_NBR;
        end
      end
      sne_pkg::S_NBR: begin
        node_next = nbr_rd;
        src_next = nbr_rd;
        flag_ra = nbr_rd;
        ndp_ra = nbr_rd;
        if ({1'b0, nbr_rd} >= nclamp) begin
          ev_next = sne_pkg::EV_INCONSIST;
          state_next = sne_pkg::S_FINISH;
        end else begin
          state_next = sne_pkg::S_NBR2;
        end
      end
      sne_pkg::S_NBR2: begin
        a_reg_next = ndp_rd;
        ndp_ra = src - 1'b1;
        if (flag_rd) begin
          ev_next = sne_pkg::EV_ALREADY;
          state_next = sne_pkg::S_FINISH;
        end else if (n_inf >= NMAX) begin
          ev_next = sne_pkg::EV_INCONSIST;
          state_next = sne_pkg::S_FINISH;
        end else begin
          state_next = sne_pkg::S_INF_WR;
        end
      end
      // append the new infected node
      sne_pkg::S_INF_WR: begin
        lst_we = 1'b1;
        lst_wa = n_inf[NW-1:0];
        lst_wd = src;
        idp_we = 1'b1;
        idp_wa = n_inf[NW-1:0];
        idp_wd = ptot + deg_calc;
        flag_we = 1'b1;
        flag_wa = src;
        flag_wd = 1'b1;
        infected_total_next = n_inf + 1'b1;
        ev_next = sne_pkg::EV_INFECTION;
        state_next = sne_pkg::S_FINISH;
      end

      sne_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = sne_pkg::S_IDLE;
        end
      end

      default: state_next = sne_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sne_pkg::S_IDLE;
      infected_total <= '0;
      infection_rate <= sne_pkg::INFECTION_RATE_RESET;
      node_count <= sne_pkg::NODE_COUNT_RESET;
      out_valid <= 1'b0;
      sw_v <= 1'b0;
    end else begin
      state <= state_next;
      infected_total <= infected_total_next;
      sw_v <= (state == sne_pkg::S_START) && !sc[NW];
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (sne_pkg::reg_index_t'(cfg_index))
          sne_pkg::REG_INFECTION_RATE: infection_rate <= cfg_data;
          sne_pkg::REG_NODE_COUNT:     node_count <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ev <= ev_next;  node <= node_next;  rate_out <= rate_out_next;
    prod <= prod_next;  rate <= rate_next;  q <= q_next;  frac <= frac_next;
    n_inf <= n_inf_next;  ptot <= ptot_next;  a_reg <= a_reg_next;  k <= k_next;
    lower <= lower_next;  upper <= upper_next;  mid <= mid_next;  j <= j_next;
    src <= src_next;  rem <= rem_next;  nr_sh <= nr_sh_next;  r_in <= r_in_next;
    bit_cnt <= bit_cnt_next;  sc <= sc_next;  sc_d <= sc[NW-1:0];
    if (out_load) begin
      event_kind <= ev;
      affected_node <= node;
      infected_count <= infected_total;
      total_rate <= rate_out;
    end
  end

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    infected_total <= NMAX)
    else $error("infected count above node capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_move_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == sne_pkg::S_REC_MOVE) |-> (({1'b0, j} + 1'b1) < n_inf))
    else $error("list compaction past the infected list end");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind <= sne_pkg::EV_INCONSIST))
    else $error("undefined event code");

endmodule

`default_nettype wire

/* tb/sis_network_event_step_core_test.sv */
// ----------------------------------------------------------------------------
// sis_network_event_step_core_test
// Self-checking bench for the SIS network event step core. A short table of
// directed transactions is followed by random graphs, trials and event steps.
// Every result is checked field by field against a fixed outcome or a local
// prediction of the epidemic state, with random idle bursts on input and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_network_event_step_core_test;
  import sne_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int STEP_GOAL   = 540;
  localparam int CALM_AFTER  = 470;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    event_t      kind;
    logic [9:0]  node;
    logic [10:0] count;
    logic [29:0] rate;
  } outcome_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  op;
    logic [12:0] idx;
    logic [13:0] val;
    logic [15:0] data;
    logic [31:0] r;
    logic [31:0] nr;
    bit          known;
    outcome_t    typed;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [12:0] table_index;
  logic [13:0] table_value;
  logic [31:0] choice_random;
  logic [31:0] neighbor_random;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  event_kind;
  logic [9:0]  affected_node;
  logic [10:0] infected_count;
  logic [29:0] total_rate;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  bit calm;
  bit hold_req;
  bit failed;
  int cycles;

  outcome_t pending_events[$];

  // predicted epidemic state
  logic [15:0] lambda_m;
  logic [10:0] nodes_m;
  logic [13:0] deg_pfx [MAX_NODES];
  logic [9:0]  nbr_tab [MAX_DIRECTED_EDGES];
  bit          inf_flag [MAX_NODES];
  logic [9:0]  inf_list [MAX_NODES];
  logic [13:0] inf_pfx [MAX_NODES];
  int unsigned inf_total;

  sis_network_event_step_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .table_index(table_index), .table_value(table_value),
    .choice_random(choice_random), .neighbor_random(neighbor_random),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .affected_node(affected_node),
    .infected_count(infected_count), .total_rate(total_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned active_nodes();
    return (nodes_m > MAX_NODES) ? MAX_NODES : nodes_m;
  endfunction

  function automatic logic [13:0] list_deg(int unsigned i);
    if (i == 0) return inf_pfx[0];
    return inf_pfx[i] - inf_pfx[i-1];
  endfunction

  function automatic logic [13:0] graph_deg(int unsigned v);
    if (v == 0) return deg_pfx[0];
    return deg_pfx[v] - deg_pfx[v-1];
  endfunction

  // one gillespie event on the predicted state
  task automatic draw_event(input logic [31:0] r, input logic [31:0] nr,
                            output event_t ev, output logic [9:0] node,
                            output logic [63:0] rate);
    int unsigned n, lo, hi, vs, pos, k;
    logic [63:0] prod, q, rec, th;
    bit frac;
    longint slot;
    logic [9:0] src, ve;
    n = inf_total;
    node = '0;
    rate = '0;
    ev = EV_EXTINCT;
    if (n == 0) return;
    rate = lambda_m * inf_pfx[n-1] + (64'(n) << RATE_FRACTION_BITS);
    prod = {31'b0, r, 1'b1} * rate;
    q = prod >> 33;
    frac = |prod[32:0];
    rec = 64'(n) << RATE_FRACTION_BITS;
    ev = EV_INCONSIST;
    // recovery: drop the node and compact the list
    if (q < rec) begin
      pos = q >> RATE_FRACTION_BITS;
      node = inf_list[pos];
      if (!inf_flag[node]) return;
      inf_flag[node] = 1'b0;
      k = list_deg(pos);
      for (int j = pos; j + 1 < n; j++) begin
        inf_pfx[j] = inf_pfx[j+1] - k[13:0];
        inf_list[j] = inf_list[j+1];
      end
      inf_total = n - 1;
      ev = EV_RECOVERY;
      return;
    end
    // infection: bisection over infected prefix degrees
    q = q - rec;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      vs = (lo + hi) / 2;
      th = lambda_m * inf_pfx[vs];
      if (q > th || (q == th && frac)) lo = vs + 1;
      else hi = vs;
    end
    src = inf_list[lo];
    node = src;
    th = lambda_m * inf_pfx[lo];
    if (q > th || (q == th && frac)) return;
    k = list_deg(lo);
    if (k == 0) return;
    slot = longint'(deg_pfx[src]) - longint'(nr % k) - 1;
    if (slot < 0 || slot >= MAX_DIRECTED_EDGES) return;
    ve = nbr_tab[slot];
    node = ve;
    if (ve >= active_nodes()) return;
    if (inf_flag[ve]) begin
      ev = EV_ALREADY;
      return;
    end
    if (n >= MAX_NODES) return;
    inf_list[n] = ve;
    inf_pfx[n] = inf_pfx[n-1] + graph_deg(ve);
    inf_flag[ve] = 1'b1;
    inf_total = n + 1;
    ev = EV_INFECTION;
  endtask

  task automatic predict_outcome(input logic [1:0] op, input logic [12:0] idx,
                                 input logic [13:0] val, input logic [31:0] r,
                                 input logic [31:0] nr, output outcome_t res);
    event_t ev;
    logic [9:0] node;
    logic [63:0] rate;
    int unsigned cap;
    ev = EV_DONE;
    node = '0;
    rate = '0;
    case (op)
      OP_LOAD_DEGREE: if (idx < MAX_NODES) deg_pfx[idx] = val;
      OP_LOAD_NEIGHBOR: nbr_tab[idx] = val[9:0];
      OP_START: begin
        cap = active_nodes();
        for (int i = 0; i < MAX_NODES; i++) begin
          inf_flag[i] = (i < cap);
          if (i < cap) begin
            inf_list[i] = i[9:0];
            inf_pfx[i] = deg_pfx[i];
          end
        end
        inf_total = cap;
      end
      default: draw_event(r, nr, ev, node, rate);
    endcase
    res.kind = ev;
    res.node = node;
    res.count = inf_total[10:0];
    res.rate = (rate > 64'h3FFFFFFF) ? 30'h3FFFFFFF : rate[29:0];
  endtask

  // offer one transaction, with an optional idle burst in front
  task automatic offer(input logic [1:0] op, input logic [12:0] idx, input logic [13:0] val,
                       input logic [31:0] r, input logic [31:0] nr,
                       input bit known, input outcome_t typed);
    outcome_t got;
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    table_index <= idx;
    table_value <= val;
    choice_random <= r;
    neighbor_random <= nr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_outcome(op, idx, val, r, nr, got);
    pending_events.push_back(known ? typed : got);
  endtask

  task automatic step_item(input logic [31:0] r, input logic [31:0] nr);
    offer(OP_STEP, '0, '0, r, nr, 1'b0, '0);
  endtask

  // sender pause until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t which, input logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (which == REG_INFECTION_RATE) lambda_m = data;
    else nodes_m = data[10:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 7) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result kind %0d node %0d", $time, event_kind,
                 affected_node);
        failed = 1'b1;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, event_kind);
          failed = 1'b1;
        end
        if (affected_node !== want.node) begin
          $display("%0t: affected_node expected %0d actual %0d", $time, want.node,
                   affected_node);
          failed = 1'b1;
        end
        if (infected_count !== want.count) begin
          $display("%0t: infected_count expected %0d actual %0d", $time, want.count,
                   infected_count);
          failed = 1'b1;
        end
        if (total_rate !== want.rate) begin
          $display("%0t: total_rate expected %0d actual %0d", $time, want.rate, total_rate);
          failed = 1'b1;
        end
      end
    end
  end

  // directed opening: empty trials, an ignored degree load, a four node graph
  localparam outcome_t IDLE_DONE = '{EV_DONE, 10'd0, 11'd0, 30'd0};
  localparam outcome_t NO_INFECT = '{EV_EXTINCT, 10'd0, 11'd0, 30'd0};
  localparam outcome_t FOUR_UP   = '{EV_DONE, 10'd0, 11'd4, 30'd0};

  row_t plan [24] = '{
    '{1, OP_STEP, 13'd1, 14'd0, 16'd0, 32'd0, 32'd0, 0, IDLE_DONE},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 1, NO_INFECT},
    '{0, OP_START, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, NO_INFECT},
    '{0, OP_LOAD_DEGREE, 13'd8191, 14'd8192, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_NEIGHBOR, 13'd8191, 14'd8192, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{1, OP_STEP, 13'd1, 14'd0, 16'd4, 32'd0, 32'd0, 0, IDLE_DONE},
    '{1, OP_STEP, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 0, IDLE_DONE},
    '{0, OP_LOAD_DEGREE, 13'd0, 14'd2, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_DEGREE, 13'd1, 14'd3, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_DEGREE, 13'd2, 14'd3, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_DEGREE, 13'd3, 14'd4, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_NEIGHBOR, 13'd0, 14'd1, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_NEIGHBOR, 13'd1, 14'd3, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_NEIGHBOR, 13'd2, 14'd0, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_LOAD_NEIGHBOR, 13'd3, 14'd5, 16'd0, 32'd0, 32'd0, 1, IDLE_DONE},
    '{0, OP_START, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 1, FOUR_UP},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 1,
      '{EV_RECOVERY, 10'd0, 11'd3, 30'd65536}},
    '{1, OP_STEP, 13'd0, 14'd0, 16'hFFFF, 32'd0, 32'd0, 0, IDLE_DONE},
    '{0, OP_START, 13'd0, 14'd0, 16'd0, 32'd0, 32'd0, 1, FOUR_UP},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'hFFFFFFFF, 32'd0, 0, IDLE_DONE},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'h80000000, 32'hFFFFFFFF, 0, IDLE_DONE},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'hC0000000, 32'd1, 0, IDLE_DONE},
    '{0, OP_STEP, 13'd0, 14'd0, 16'd0, 32'hF0000000, 32'd2, 0, IDLE_DONE}
  };

  // stimulus
  initial begin
    int steps, n, p, burst;
    logic [13:0] v;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    table_index = '0;
    table_value = '0;
    choice_random = '0;
    neighbor_random = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_INFECTION_RATE;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    failed = 1'b0;
    cycles = 0;
    lambda_m = INFECTION_RATE_RESET;
    nodes_m = NODE_COUNT_RESET;
    inf_total = 0;
    foreach (inf_flag[i]) inf_flag[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg)
        write_reg(reg_index_t'(plan[i].idx[0]), plan[i].data);
      else
        offer(plan[i].op, plan[i].idx, plan[i].val, plan[i].r, plan[i].nr,
              plan[i].known, plan[i].typed);
    end

    // full graph: every degree entry and every edge slot gets written once
    write_reg(REG_NODE_COUNT, 16'd2047);
    write_reg(REG_INFECTION_RATE, 16'($urandom_range(0, 65535)));
    p = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      p += $urandom_range(0, 7);
      offer(OP_LOAD_DEGREE, 13'(i), 14'(p), '0, '0, 1'b0, '0);
    end
    for (int s = 0; s < MAX_DIRECTED_EDGES; s++) begin
      v = (s < p) ? 14'($urandom_range(0, 1023)) : 14'($urandom_range(0, 8192));
      offer(OP_LOAD_NEIGHBOR, 13'(s), v, '0, '0, 1'b0, '0);
    end
    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    offer(OP_START, '0, '0, '0, '0, 1'b0, '0);
    for (int j = 0; j < 20; j++) step_item($urandom, $urandom);
    write_reg(REG_NODE_COUNT, 16'd1024);
    write_reg(REG_INFECTION_RATE, 16'hFFFF);
    offer(OP_START, '0, '0, '0, '0, 1'b0, '0);
    for (int j = 0; j < 10; j++) step_item($urandom, $urandom);

    // random graphs and trials
    steps = 0;
    while (steps < STEP_GOAL) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_INFECTION_RATE, 16'd0);
        1: write_reg(REG_INFECTION_RATE, 16'hFFFF);
        default: write_reg(REG_INFECTION_RATE, 16'($urandom_range(0, 65535)));
      endcase
      n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      write_reg(REG_NODE_COUNT, 16'(n));
      p = 0;
      for (int i = 0; i < n; i++) begin
        p += $urandom_range(0, 6);
        v = ($urandom_range(0, 29) == 0) ? 14'($urandom_range(0, 8192)) : 14'(p);
        offer(OP_LOAD_DEGREE, 13'(i), v, '0, '0, 1'b0, '0);
      end
      for (int s = 0; s < p; s++) begin
        v = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 8192))
                                         : 14'($urandom_range(0, n - 1));
        offer(OP_LOAD_NEIGHBOR, 13'(s), v, '0, '0, 1'b0, '0);
      end
      offer(OP_START, '0, '0, '0, '0, 1'b0, '0);
      burst = $urandom_range(20, 60);
      for (int j = 0; j < burst; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: stray neighbor writes, ignored degree loads, restarts
          case ($urandom_range(0, 2))
            0: offer(OP_LOAD_NEIGHBOR, 13'($urandom_range(0, 8191)),
                     14'($urandom_range(0, 8192)), '0, '0, 1'b0, '0);
            1: offer(OP_LOAD_DEGREE, 13'($urandom_range(1024, 8191)),
                     14'($urandom_range(0, 8192)), '0, '0, 1'b0, '0);
            default: offer(OP_START, '0, '0, '0, '0, 1'b0, '0);
          endcase
        end else begin
          case ($urandom_range(0, 15))
            0: step_item(32'd0, $urandom);
            1: step_item(32'hFFFFFFFF, $urandom);
            default: step_item($urandom, $urandom);
          endcase
          steps++;
          calm = (steps > CALM_AFTER);
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (failed)
      $display("TEST FAILED");
    else
      $display("TEST PASSED");
    $finish;
  end

endmodule

/* sis_network_event_step_core.f */
hdl/sne_pkg.sv
hdl/sis_network_event_step_core.sv
tb/sis_network_event_step_core_test.sv
